[rtl/adc_command_sequencer_unit_defines.svh]
// Assertion macros shared by the sequencer's checker.
`ifndef ADC_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define ADC_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adc sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adc sequencer: next-cycle check failed");

`endif

[rtl/acs_pkg.sv]
// Types and constants shared by the ADC command sequencer modules.
`default_nettype none

package acs_pkg;

   // Field widths.
   localparam int CMD_W       = 2;
   localparam int SAMPLE_W    = 16;
   localparam int SLOTS_W     = 3;
   localparam int COUNT_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Ring size after reset.
   localparam int QUEUE_SLOTS_RESET = 4;

   // Request kinds.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Command codes, which double as converter channel numbers.
   localparam logic [CMD_W-1:0] CMD_IDLE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEMP     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HUMIDITY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_BATTERY  = 2'd3;

   // Push status codes.
   localparam logic [1:0] PUSH_ADDED = 2'd0;
   localparam logic [1:0] PUSH_FULL  = 2'd1;
   localparam logic [1:0] PUSH_TICK  = 2'd2;

   // Phase codes as reported in the response.
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_CONFIG  = 2'd1;
   localparam logic [1:0] PHASE_MEASURE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_QUEUE_SLOTS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_SAMPLES     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HUMIDITY_SAMPLES = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BATTERY_SAMPLES  = 2'd3;

   // Input request payload.
   typedef struct packed {
      logic                func;
      logic [CMD_W-1:0]    command;
      logic [SAMPLE_W-1:0] adc_sample;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [1:0]          push_status;
      logic [1:0]          phase;
      logic                configure_strobe;
      logic [CMD_W-1:0]    configure_channel;
      logic                sample_taken;
      logic [SAMPLE_W-1:0] temperature;
      logic [SAMPLE_W-1:0] humidity;
      logic [SAMPLE_W-1:0] battery_level;
      logic [SAMPLE_W-1:0] temp_count;
      logic [SAMPLE_W-1:0] humidity_count;
      logic [SAMPLE_W-1:0] battery_count;
   } rsp_type;

   // Classified request as held in the queue between front and back.
   typedef struct packed {
      logic                is_tick;
      logic [CMD_W-1:0]    command;
      logic [SAMPLE_W-1:0] sample;
   } op_type;

   // One configuration write.
   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // Commands from the back end to the command ring.
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [CMD_W-1:0] command;
   } ring_ctrl_type;

   // Status of the command ring.
   typedef struct packed {
      logic             full;
      logic             empty;
      logic [CMD_W-1:0] head;
   } ring_status_type;

endpackage

`default_nettype wire

[rtl/acs_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module acs_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  acs_pkg::req_type      req_data,
   output logic                  q_valid,
   output acs_pkg::op_type       q_data,
   input  wire                   q_take
);

   acs_pkg::op_type q_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            push;
   acs_pkg::op_type op;

   // Classify the request into a queue entry.
   always_comb begin
      op.is_tick = (req_data.func == acs_pkg::FUNC_TICK);
      op.command = req_data.command;
      op.sample  = req_data.adc_sample;
   end

   // Two-entry queue; stall only when both entries hold a request.
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_take) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op;
      end
   end

endmodule

`default_nettype wire

[rtl/acs_ring.sv]
// Command ring: circular store of pending commands that keeps one slot free.
`default_nettype none

module acs_ring #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  acs_pkg::csr_write_type  csr,
   input  acs_pkg::ring_ctrl_type  ctrl,
   output acs_pkg::ring_status_type status
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CMP_W  = (SLOT_W + 1 > acs_pkg::SLOTS_W) ? SLOT_W + 1 : acs_pkg::SLOTS_W;
   localparam logic [CMP_W-1:0] DEPTH_MAX = CMP_W'(QUEUE_DEPTH);
   localparam logic [acs_pkg::SLOTS_W-1:0] SLOTS_RESET =
      (QUEUE_DEPTH < acs_pkg::QUEUE_SLOTS_RESET) ? acs_pkg::SLOTS_W'(QUEUE_DEPTH)
                                                 : acs_pkg::SLOTS_W'(acs_pkg::QUEUE_SLOTS_RESET);

   logic [acs_pkg::CMD_W-1:0]   entries_ff [QUEUE_DEPTH];
   logic [SLOT_W-1:0]           write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]           read_slot_ff, read_slot_in;
   logic [acs_pkg::SLOTS_W-1:0] queue_slots_ff, queue_slots_in;
   logic [CMP_W-1:0]            wr_inc, rd_inc, slots_ext, size_value;
   logic [SLOT_W-1:0]           wr_next, rd_next;
   logic                        size_write;

   // Next slot positions, wrapping at the ring size in use.
   always_comb begin
      slots_ext = CMP_W'(queue_slots_ff);
      wr_inc    = CMP_W'(write_slot_ff) + CMP_W'(1);
      rd_inc    = CMP_W'(read_slot_ff) + CMP_W'(1);
      wr_next   = (wr_inc >= slots_ext) ? '0 : SLOT_W'(wr_inc);
      rd_next   = (rd_inc >= slots_ext) ? '0 : SLOT_W'(rd_inc);
   end

   assign status.full  = (wr_next == read_slot_ff);
   assign status.empty = (write_slot_ff == read_slot_ff);
   assign status.head  = entries_ff[read_slot_ff];

   // A ring size, taken from the low SLOTS_W bits of the data, outside one to QUEUE_DEPTH is ignored.
   always_comb begin
      size_value = CMP_W'(csr.data[acs_pkg::SLOTS_W-1:0]);
      size_write = csr.en && (csr.index == acs_pkg::REG_QUEUE_SLOTS) &&
                   (size_value >= CMP_W'(1)) && (size_value <= DEPTH_MAX);
   end

   always_comb begin
      queue_slots_in = queue_slots_ff;
      write_slot_in  = write_slot_ff;
      read_slot_in   = read_slot_ff;
      if (size_write) begin
         queue_slots_in = csr.data[acs_pkg::SLOTS_W-1:0];
         write_slot_in  = '0;
         read_slot_in   = '0;
      end else begin
         if (ctrl.push) begin
            write_slot_in = wr_next;
         end
         if (ctrl.pop) begin
            read_slot_in = rd_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_slots_ff <= SLOTS_RESET;
         write_slot_ff  <= '0;
         read_slot_ff   <= '0;
      end else begin
         queue_slots_ff <= queue_slots_in;
         write_slot_ff  <= write_slot_in;
         read_slot_ff   <= read_slot_in;
      end
   end

   // Entries are only read after being written since the ring was last emptied.
   always_ff @(posedge clock) begin
      if (ctrl.push && !size_write) begin
         entries_ff[write_slot_ff] <= ctrl.command;
      end
   end

endmodule

`default_nettype wire

[rtl/acs_back.sv]
// Back end: carries out pushes and sequencer steps and registers the response.
`default_nettype none

module acs_back (
   input  wire                      clock,
   input  wire                      reset,
   input  acs_pkg::csr_write_type   csr,
   input  wire                      q_valid,
   input  acs_pkg::op_type          q_data,
   output logic                     q_take,
   input  acs_pkg::ring_status_type ring_status,
   output acs_pkg::ring_ctrl_type   ring_ctrl,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output acs_pkg::rsp_type         rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE    = acs_pkg::PHASE_IDLE,
      ST_CONFIG  = acs_pkg::PHASE_CONFIG,
      ST_MEASURE = acs_pkg::PHASE_MEASURE
   } state_type;

   state_type                     state_ff, state_in;
   logic [acs_pkg::CMD_W-1:0]     active_ff, active_in;
   logic [acs_pkg::COUNT_W-1:0]   left_ff, left_in;
   logic [acs_pkg::SAMPLE_W-1:0]  reading_ff [3];
   logic [acs_pkg::SAMPLE_W-1:0]  reading_in [3];
   logic [acs_pkg::SAMPLE_W-1:0]  counter_ff [3];
   logic [acs_pkg::SAMPLE_W-1:0]  counter_in [3];
   logic [acs_pkg::COUNT_W-1:0]   temp_samples_ff, temp_samples_in;
   logic [acs_pkg::COUNT_W-1:0]   humidity_samples_ff, humidity_samples_in;
   logic [acs_pkg::COUNT_W-1:0]   battery_samples_ff, battery_samples_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   acs_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [1:0]                    chan_idx;
   logic [acs_pkg::COUNT_W-1:0]   load_count;
   logic [acs_pkg::COUNT_W-1:0]   raw_count;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Take a queued request whenever the response register is free or drains.
   assign q_take = q_valid && (!rsp_valid_ff || !rsp_stall);

   // Sample count for the active command; a zero register means one sample.
   always_comb begin
      unique case (active_ff)
         acs_pkg::CMD_TEMP:     raw_count = temp_samples_ff;
         acs_pkg::CMD_HUMIDITY: raw_count = humidity_samples_ff;
         acs_pkg::CMD_BATTERY:  raw_count = battery_samples_ff;
         default:               raw_count = '0;
      endcase
      if (active_ff == acs_pkg::CMD_IDLE) begin
         load_count = '0;
      end else if (raw_count == '0) begin
         load_count = acs_pkg::COUNT_W'(1);
      end else begin
         load_count = raw_count;
      end
   end

   // Configuration writes to the sample count registers.
   always_comb begin
      temp_samples_in     = temp_samples_ff;
      humidity_samples_in = humidity_samples_ff;
      battery_samples_in  = battery_samples_ff;
      if (csr.en) begin
         case (csr.index)
            acs_pkg::REG_TEMP_SAMPLES:     temp_samples_in     = csr.data;
            acs_pkg::REG_HUMIDITY_SAMPLES: humidity_samples_in = csr.data;
            acs_pkg::REG_BATTERY_SAMPLES:  battery_samples_in  = csr.data;
            default:                       temp_samples_in     = temp_samples_ff;
         endcase
      end
   end

   // One step of the sequencer, or one push into the ring.
   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      left_in    = left_ff;
      reading_in = reading_ff;
      counter_in = counter_ff;
      chan_idx   = active_ff - 2'd1;

      ring_ctrl.push    = 1'b0;
      ring_ctrl.pop     = 1'b0;
      ring_ctrl.command = q_data.command;

      rsp_data_in                   = rsp_data_ff;
      rsp_data_in.push_status       = acs_pkg::PUSH_TICK;
      rsp_data_in.configure_strobe  = 1'b0;
      rsp_data_in.configure_channel = acs_pkg::CMD_IDLE;
      rsp_data_in.sample_taken      = 1'b0;

      if (q_take) begin
         if (!q_data.is_tick) begin
            ring_ctrl.push          = !ring_status.full;
            rsp_data_in.push_status = ring_status.full ? acs_pkg::PUSH_FULL
                                                       : acs_pkg::PUSH_ADDED;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (!ring_status.empty) begin
                     ring_ctrl.pop = 1'b1;
                     active_in     = ring_status.head;
                     state_in      = ST_CONFIG;
                  end
               end
               ST_CONFIG: begin
                  rsp_data_in.configure_strobe  = 1'b1;
                  rsp_data_in.configure_channel = active_ff;
                  left_in                       = load_count;
                  state_in                      = ST_MEASURE;
               end
               default: begin
                  // An idle command takes no sample.
                  if (active_ff != acs_pkg::CMD_IDLE) begin
                     reading_in[chan_idx]     = q_data.sample;
                     counter_in[chan_idx]     = counter_ff[chan_idx] + 16'd1;
                     rsp_data_in.sample_taken = 1'b1;
                  end
                  if (left_ff <= acs_pkg::COUNT_W'(1)) begin
                     left_in = '0;
                     if (!ring_status.empty) begin
                        ring_ctrl.pop = 1'b1;
                        active_in     = ring_status.head;
                        state_in      = ST_CONFIG;
                     end else begin
                        state_in   = ST_IDLE;
                        counter_in = '{default: '0};
                     end
                  end else begin
                     left_in = left_ff - acs_pkg::COUNT_W'(1);
                  end
               end
            endcase
         end
      end

      rsp_data_in.phase          = state_in;
      rsp_data_in.temperature    = reading_in[0];
      rsp_data_in.humidity       = reading_in[1];
      rsp_data_in.battery_level  = reading_in[2];
      rsp_data_in.temp_count     = counter_in[0];
      rsp_data_in.humidity_count = counter_in[1];
      rsp_data_in.battery_count  = counter_in[2];

      rsp_valid_in = q_take || (rsp_valid_ff && rsp_stall);
   end

   // Sequencer state, configuration and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         active_ff           <= acs_pkg::CMD_IDLE;
         left_ff             <= '0;
         reading_ff          <= '{default: '0};
         counter_ff          <= '{default: '0};
         temp_samples_ff     <= acs_pkg::COUNT_W'(1);
         humidity_samples_ff <= acs_pkg::COUNT_W'(1);
         battery_samples_ff  <= acs_pkg::COUNT_W'(1);
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         active_ff           <= active_in;
         left_ff             <= left_in;
         reading_ff          <= reading_in;
         counter_ff          <= counter_in;
         temp_samples_ff     <= temp_samples_in;
         humidity_samples_ff <= humidity_samples_in;
         battery_samples_ff  <= battery_samples_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      if (q_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

[rtl/adc_command_sequencer_unit.sv]
// Each request passes through the front queue; the back end then registers its response.
// Throughput: one request per cycle while the response port is not stalled, and a
// two-entry queue decouples intake from the response port.
// Reset is synchronous and active high: it empties the queue and the ring, returns the
// sequencer to idle, clears readings and counters and restores the configuration
// registers to ring size four and one sample per command; ring entries stay as they were.
`default_nettype none

module adc_command_sequencer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  acs_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output acs_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_wen,
   input  wire  [acs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [acs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   acs_pkg::csr_write_type   csr;
   acs_pkg::op_type          q_data;
   logic                     q_valid;
   logic                     q_take;
   acs_pkg::ring_ctrl_type   ring_ctrl;
   acs_pkg::ring_status_type ring_status;

   // Bundle the configuration write for the units that decode it.
   always_comb begin
      csr.en    = csr_wen;
      csr.index = csr_index;
      csr.data  = csr_wdata;
   end

   acs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_take    (q_take)
   );

   acs_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .ctrl   (ring_ctrl),
      .status (ring_status)
   );

   acs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_take      (q_take),
      .ring_status (ring_status),
      .ring_ctrl   (ring_ctrl),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/acs_checker.sv]
// Port-level checker for the ADC command sequencer and its bind.
`default_nettype none
`include "adc_command_sequencer_unit_defines.svh"

module acs_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             rsp_valid,
   input wire                             rsp_stall,
   input acs_pkg::rsp_type                rsp_data
);

   logic rsp_is_push;
   logic push_quiet;
   logic strobe_moves_on;
   logic reports_idle;
   logic counts_clear;

   // Decode the response fields that the checks look at.
   assign rsp_is_push     = (rsp_data.push_status != acs_pkg::PUSH_TICK);
   assign push_quiet      = !rsp_data.configure_strobe && !rsp_data.sample_taken &&
                            (rsp_data.configure_channel == acs_pkg::CMD_IDLE);
   assign strobe_moves_on = (rsp_data.phase == acs_pkg::PHASE_MEASURE) && !rsp_is_push &&
                            !rsp_data.sample_taken;
   assign reports_idle    = (rsp_data.phase == acs_pkg::PHASE_IDLE);
   assign counts_clear    = (rsp_data.temp_count == '0) && (rsp_data.humidity_count == '0) &&
                            (rsp_data.battery_count == '0);

   // A stalled response stays valid and unchanged.
   `ACS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A push response never strobes the converter or takes a sample.
   `ACS_ASSERT_SAME(a_push_quiet, rsp_valid && rsp_is_push, push_quiet)

   // A configure strobe always moves the sequencer on to measuring.
   `ACS_ASSERT_SAME(a_strobe_phase, rsp_valid && rsp_data.configure_strobe, strobe_moves_on)

   // Whenever the sequencer reports idle, its sample counters are clear.
   `ACS_ASSERT_SAME(a_idle_counts, rsp_valid && reports_idle, counts_clear)

endmodule

bind adc_command_sequencer_unit acs_checker u_acs_checker (.*);

`default_nettype wire

[tb/sv/sequencer_response_checker.sv]
// Checker for the ADC command sequencer: predicts every response and compares it.
module sequencer_response_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  acs_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  acs_pkg::rsp_type                rsp_data,
   input  logic                            csr_wen,
   input  logic [acs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [acs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              failures,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = 4;

   // Register copies.
   logic [acs_pkg::SLOTS_W-1:0] ring_size = acs_pkg::SLOTS_W'(acs_pkg::QUEUE_SLOTS_RESET);
   logic [acs_pkg::COUNT_W-1:0] temp_n = 8'd1;
   logic [acs_pkg::COUNT_W-1:0] humidity_n = 8'd1;
   logic [acs_pkg::COUNT_W-1:0] battery_n = 8'd1;

   // Sequencer and ring state as the block should hold it.
   logic [acs_pkg::CMD_W-1:0]    ring_mem [RING_DEPTH];
   logic [1:0]                   wr_slot = '0;
   logic [1:0]                   rd_slot = '0;
   logic [1:0]                   seq_phase = acs_pkg::PHASE_IDLE;
   logic [acs_pkg::CMD_W-1:0]    active_cmd = acs_pkg::CMD_IDLE;
   logic [acs_pkg::COUNT_W-1:0]  samples_left = '0;
   logic [acs_pkg::SAMPLE_W-1:0] readings [3] = '{default: '0};
   logic [acs_pkg::SAMPLE_W-1:0] sample_counts [3] = '{default: '0};

   acs_pkg::rsp_type expected_responses [$];
   int               error_total = 0;

   // Removes the oldest command from the ring, if there is one.
   task automatic take_from_ring(output bit got, output logic [acs_pkg::CMD_W-1:0] cmd);
      int nxt;
      got = (wr_slot != rd_slot);
      cmd = acs_pkg::CMD_IDLE;
      if (got) begin
         cmd = ring_mem[rd_slot];
         nxt = int'(rd_slot) + 1;
         if (nxt >= int'(ring_size)) nxt = 0;
         rd_slot = 2'(nxt);
      end
   endtask

   // Applies one request to the predicted state and forms its response.
   task automatic step_sequencer(input acs_pkg::req_type r, output acs_pkg::rsp_type e);
      logic [acs_pkg::CMD_W-1:0] next_cmd;
      bit                        got;
      int                        nxt;
      logic [1:0]                chan;
      e = '0;
      e.push_status = acs_pkg::PUSH_TICK;
      chan = active_cmd - 2'd1;
      if (r.func == acs_pkg::FUNC_PUSH) begin
         // The ring always keeps one slot free.
         nxt = int'(wr_slot) + 1;
         if (nxt >= int'(ring_size)) nxt = 0;
         if (nxt == int'(rd_slot)) begin
            e.push_status = acs_pkg::PUSH_FULL;
         end else begin
            ring_mem[wr_slot] = r.command;
            wr_slot = 2'(nxt);
            e.push_status = acs_pkg::PUSH_ADDED;
         end
      end else if (seq_phase == acs_pkg::PHASE_IDLE) begin
         take_from_ring(got, next_cmd);
         if (got) begin
            active_cmd = next_cmd;
            seq_phase = acs_pkg::PHASE_CONFIG;
         end
      end else if (seq_phase == acs_pkg::PHASE_CONFIG) begin
         e.configure_strobe = 1'b1;
         e.configure_channel = active_cmd;
         case (active_cmd)
            acs_pkg::CMD_TEMP: begin
               samples_left = temp_n;
            end
            acs_pkg::CMD_HUMIDITY: begin
               samples_left = humidity_n;
            end
            acs_pkg::CMD_BATTERY: begin
               samples_left = battery_n;
            end
            default: begin
               samples_left = '0;
            end
         endcase
         // A sample count of zero behaves as one.
         if (active_cmd != acs_pkg::CMD_IDLE && samples_left == 0) samples_left = 8'd1;
         seq_phase = acs_pkg::PHASE_MEASURE;
      end else begin
         // The idle command takes no sample.
         if (active_cmd != acs_pkg::CMD_IDLE) begin
            readings[chan] = r.adc_sample;
            sample_counts[chan] = sample_counts[chan] + 16'd1;
            e.sample_taken = 1'b1;
         end
         if (samples_left <= 1) begin
            samples_left = '0;
            take_from_ring(got, next_cmd);
            if (got) begin
               active_cmd = next_cmd;
               seq_phase = acs_pkg::PHASE_CONFIG;
            end else begin
               seq_phase = acs_pkg::PHASE_IDLE;
               sample_counts = '{default: '0};
            end
         end else begin
            samples_left = samples_left - 8'd1;
         end
      end
      e.phase = seq_phase;
      e.temperature = readings[0];
      e.humidity = readings[1];
      e.battery_level = readings[2];
      e.temp_count = sample_counts[0];
      e.humidity_count = sample_counts[1];
      e.battery_count = sample_counts[2];
   endtask

   task automatic compare_field(input string field,
                                input logic [acs_pkg::SAMPLE_W-1:0] want,
                                input logic [acs_pkg::SAMPLE_W-1:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0h, got %0h", field, want, seen);
         error_total++;
      end
   endtask

   // Follows both channels and the register port at every edge.
   always @(posedge clock) begin : track
      acs_pkg::rsp_type want;
      acs_pkg::rsp_type predicted;
      if (reset) begin
         ring_size = acs_pkg::SLOTS_W'(acs_pkg::QUEUE_SLOTS_RESET);
         temp_n = 8'd1;
         humidity_n = 8'd1;
         battery_n = 8'd1;
         wr_slot = '0;
         rd_slot = '0;
         seq_phase = acs_pkg::PHASE_IDLE;
         active_cmd = acs_pkg::CMD_IDLE;
         samples_left = '0;
         readings = '{default: '0};
         sample_counts = '{default: '0};
         expected_responses.delete();
      end else begin
         // Register writes; an out-of-range ring size is ignored.
         if (csr_wen) begin
            case (csr_index)
               acs_pkg::REG_QUEUE_SLOTS: begin
                  if (csr_wdata[acs_pkg::SLOTS_W-1:0] >= 1 &&
                      csr_wdata[acs_pkg::SLOTS_W-1:0] <= RING_DEPTH) begin
                     ring_size = csr_wdata[acs_pkg::SLOTS_W-1:0];
                     wr_slot = '0;
                     rd_slot = '0;
                  end
               end
               acs_pkg::REG_TEMP_SAMPLES: begin
                  temp_n = csr_wdata;
               end
               acs_pkg::REG_HUMIDITY_SAMPLES: begin
                  humidity_n = csr_wdata;
               end
               acs_pkg::REG_BATTERY_SAMPLES: begin
                  battery_n = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         // Compare a delivered response with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("response delivered with no request outstanding");
               error_total++;
            end else begin
               want = expected_responses.pop_front();
               compare_field("push_status", acs_pkg::SAMPLE_W'(want.push_status),
                             acs_pkg::SAMPLE_W'(rsp_data.push_status));
               compare_field("phase", acs_pkg::SAMPLE_W'(want.phase),
                             acs_pkg::SAMPLE_W'(rsp_data.phase));
               compare_field("configure_strobe", acs_pkg::SAMPLE_W'(want.configure_strobe),
                             acs_pkg::SAMPLE_W'(rsp_data.configure_strobe));
               compare_field("configure_channel", acs_pkg::SAMPLE_W'(want.configure_channel),
                             acs_pkg::SAMPLE_W'(rsp_data.configure_channel));
               compare_field("sample_taken", acs_pkg::SAMPLE_W'(want.sample_taken),
                             acs_pkg::SAMPLE_W'(rsp_data.sample_taken));
               compare_field("temperature", want.temperature, rsp_data.temperature);
               compare_field("humidity", want.humidity, rsp_data.humidity);
               compare_field("battery_level", want.battery_level, rsp_data.battery_level);
               compare_field("temp_count", want.temp_count, rsp_data.temp_count);
               compare_field("humidity_count", want.humidity_count, rsp_data.humidity_count);
               compare_field("battery_count", want.battery_count, rsp_data.battery_count);
            end
         end
         // Predict the response of an accepted request.
         if (req_valid && !req_stall) begin
            step_sequencer(req_data, predicted);
            expected_responses.push_back(predicted);
         end
      end
      outstanding <= expected_responses.size();
      failures <= error_total;
   end

endmodule

[tb/sv/testbench.sv]
// Top level of the ADC command sequencer testbench: stimulus, flow control and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 60;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   acs_pkg::req_type                req_data = '0;
   logic                            req_stall;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   acs_pkg::rsp_type                rsp_data;
   logic                            csr_wen = 1'b0;
   logic [acs_pkg::CSR_INDEX_W-1:0] csr_index = acs_pkg::REG_QUEUE_SLOTS;
   logic [acs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int failures;
   int outstanding;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int hold_off_requests = 0;
   int hold_off_seen = 0;
   int hold_off_left = 0;

   always #5 clock = ~clock;

   adc_command_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sequencer_response_checker response_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Response side: random stalls, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_off_seen != hold_off_requests) begin
         hold_off_seen = hold_off_requests;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offers one request until it is taken, then idles at random.
   task automatic send_request(input acs_pkg::req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
   endtask

   task automatic send_push(input logic [acs_pkg::CMD_W-1:0] cmd);
      acs_pkg::req_type r;
      r.func = acs_pkg::FUNC_PUSH;
      r.command = cmd;
      r.adc_sample = acs_pkg::SAMPLE_W'($urandom);
      send_request(r);
   endtask

   task automatic send_tick(input logic [acs_pkg::SAMPLE_W-1:0] sample);
      acs_pkg::req_type r;
      r.func = acs_pkg::FUNC_TICK;
      r.command = acs_pkg::CMD_W'($urandom);
      r.adc_sample = sample;
      send_request(r);
   endtask

   // Holds the sender back until every response has been delivered.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [acs_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [acs_pkg::CSR_DATA_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic reconfigure(input logic [acs_pkg::CSR_DATA_W-1:0] slots,
                              input logic [acs_pkg::CSR_DATA_W-1:0] t,
                              input logic [acs_pkg::CSR_DATA_W-1:0] h,
                              input logic [acs_pkg::CSR_DATA_W-1:0] b);
      wait_drained();
      write_register(acs_pkg::REG_QUEUE_SLOTS, slots);
      write_register(acs_pkg::REG_TEMP_SAMPLES, t);
      write_register(acs_pkg::REG_HUMIDITY_SAMPLES, h);
      write_register(acs_pkg::REG_BATTERY_SAMPLES, b);
   endtask

   // Mostly well-formed bursts: one to three pushes followed by two up to six ticks per
   // push plus two, with some stray requests mixed in.
   task automatic run_random(input int items);
      int               sent;
      int               n_cmds;
      int               n_ticks;
      acs_pkg::req_type r;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 15) begin
            r.func = 1'($urandom);
            r.command = acs_pkg::CMD_W'($urandom);
            r.adc_sample = acs_pkg::SAMPLE_W'($urandom);
            send_request(r);
            sent++;
         end else begin
            n_cmds = $urandom_range(1, 3);
            repeat (n_cmds) send_push(acs_pkg::CMD_W'($urandom));
            n_ticks = $urandom_range(2, 6 * n_cmds + 2);
            repeat (n_ticks) send_tick(acs_pkg::SAMPLE_W'($urandom));
            sent += n_cmds + n_ticks;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a tick on an empty ring, a full ring, then the idle command
      // followed by temperature and humidity, both sampled at the maximum value.
      send_tick(16'h1234);
      send_push(acs_pkg::CMD_IDLE);
      send_push(acs_pkg::CMD_TEMP);
      send_push(acs_pkg::CMD_HUMIDITY);
      send_push(acs_pkg::CMD_BATTERY);
      for (int i = 0; i < 7; i++) send_tick((i % 2 == 0) ? 16'hFFFF : 16'h0000);

      // Pushes landing in the configure and measure phases.
      send_push(acs_pkg::CMD_BATTERY);
      send_tick(16'h0F0F);
      send_push(acs_pkg::CMD_TEMP);
      send_tick(16'hF0F0);
      send_push(acs_pkg::CMD_HUMIDITY);
      send_tick(16'h5A5A);

      // Out-of-range ring sizes are ignored; a size of one refuses every push.
      wait_drained();
      write_register(acs_pkg::REG_QUEUE_SLOTS, 8'd0);
      write_register(acs_pkg::REG_QUEUE_SLOTS, 8'd5);
      write_register(acs_pkg::REG_QUEUE_SLOTS, 8'd7);
      write_register(acs_pkg::REG_QUEUE_SLOTS, 8'd1);
      send_push(acs_pkg::CMD_TEMP);
      send_tick(16'hA5A5);
      send_tick(16'h8001);

      // A sample count of zero acts as one.
      reconfigure(8'd4, 8'd0, 8'd1, 8'd1);
      send_push(acs_pkg::CMD_TEMP);
      repeat (3) send_tick(acs_pkg::SAMPLE_W'($urandom));

      // No idling on either side, with one long hold-off on the response side.
      reconfigure(8'd4, 8'd2, 8'd3, 8'd1);
      send_gap_pct = 0;
      stall_pct <= 0;
      run_random(50);
      hold_off_requests <= hold_off_requests + 1;
      run_random(50);

      // Sender idling, with one pause until everything has drained.
      reconfigure(8'd3, 8'd1, 8'd0, 8'd4);
      send_gap_pct = 69;
      run_random(50);
      wait_drained();
      run_random(50);

      // Receiver stalling.
      reconfigure(8'd2, 8'd4, 8'd1, 8'd2);
      send_gap_pct = 0;
      stall_pct <= 69;
      run_random(100);

      // Light idling on both sides with the largest temperature count.
      reconfigure(8'd4, 8'd255, 8'd2, 8'd255);
      send_gap_pct = 9;
      stall_pct <= 9;
      run_random(100);

      wait_drained();
      repeat (5) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
